/* hw/rtl/u16u8_pkg.sv */
// ----------------------------------------------------------------------------
// u16u8_pkg: shared types and constants for the UTF-16BE / Latin-1 to UTF-8
// transcoder. Holds the front-end phase encoding and the work entry that
// travels from the front end through the queue to the byte encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    // Width of one Unicode code point
    localparam int CP_W = 21;

    // Default depth of the work queue between front end and encoder
    localparam int QUEUE_DEPTH = 4;

    // Byte order mark bytes
    localparam logic [7:0] BOM_HI = 8'hFE;
    localparam logic [7:0] BOM_LO = 8'hFF;

    // Position within a string
    typedef enum logic [1:0] {
        PH_START,   // expecting the first byte
        PH_FE,      // first byte was FE and is held
        PH_BODY     // past the start of the string
    } t_phase;

    // Work entry: up to two code points and the end-of-string flag.
    // A count of zero with last set is an end marker without a byte.
    typedef struct packed {
        logic [CP_W-1:0] cp0;
        logic [CP_W-1:0] cp1;
        logic [1:0]      n_cp;
        logic            last;
    } t_work;

endpackage

/* hw/rtl/u16u8_front.sv */
// ----------------------------------------------------------------------------
// u16u8_front: input front end
// Accepts one raw byte per cycle while the queue is not full, tracks the byte
// order mark, takes Latin-1 bytes as code points, pairs UTF-16 bytes into code
// units, joins surrogate pairs and issues a work entry with the code points.
// ----------------------------------------------------------------------------
module u16u8_front
    import u16u8_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_last_in,
    input  logic       i_q_full,
    output logic       o_push,
    output t_work      o_work
);

    localparam logic [5:0] HIGH_TAG = 6'b110110;
    localparam logic [5:0] LOW_TAG  = 6'b110111;
    localparam logic [CP_W-1:0] SUPP_BASE = CP_W'(32'h10000);

    t_phase     r_phase, n_phase;
    logic       r_utf16, n_utf16;
    logic [7:0] r_held, n_held;
    logic       r_held_vld, n_held_vld;
    logic [9:0] r_hs, n_hs;
    logic       r_pend, n_pend;

    logic            accept;
    logic [15:0]     unit;
    logic            is_high;
    logic            is_low;
    logic [CP_W-1:0] pair_cp;
    logic [CP_W-1:0] c0, c1;
    logic [1:0]      cnt;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    // Classify the incoming code unit
    assign unit    = {r_held, i_in_byte};
    assign is_high = (unit[15:10] == HIGH_TAG);
    assign is_low  = (unit[15:10] == LOW_TAG);
    assign pair_cp = SUPP_BASE + {1'b0, r_hs, unit[9:0]};

    // Hold state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_utf16    <= 1'b0;
            r_held_vld <= 1'b0;
            r_pend     <= 1'b0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_utf16    <= n_utf16;
            r_held_vld <= n_held_vld;
            r_pend     <= n_pend;
        end
    end

    // Hold the waiting byte and high surrogate bits
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
            r_hs   <= n_hs;
        end
    end

    // Decode one byte into code points and next state
    always_comb begin
        n_phase    = r_phase;
        n_utf16    = r_utf16;
        n_held     = r_held;
        n_held_vld = r_held_vld;
        n_hs       = r_hs;
        n_pend     = r_pend;
        c0         = '0;
        c1         = '0;
        cnt        = 2'd0;

        case (r_phase)
            PH_START: begin
                if (i_in_byte == BOM_HI && !i_last_in) begin
                    n_phase = PH_FE;
                end else begin
                    c0      = CP_W'(i_in_byte);
                    cnt     = 2'd1;
                    n_phase = PH_BODY;
                    n_utf16 = 1'b0;
                end
            end
            PH_FE: begin
                n_phase = PH_BODY;
                if (i_in_byte == BOM_LO) begin
                    n_utf16    = 1'b1;
                    n_held_vld = 1'b0;
                end else begin
                    n_utf16 = 1'b0;
                    c0      = CP_W'(BOM_HI);
                    c1      = CP_W'(i_in_byte);
                    cnt     = 2'd2;
                end
            end
            default: begin
                if (!r_utf16) begin
                    c0  = CP_W'(i_in_byte);
                    cnt = 2'd1;
                end else if (!r_held_vld) begin
                    n_held     = i_in_byte;
                    n_held_vld = 1'b1;
                end else begin
                    n_held_vld = 1'b0;
                    if (r_pend && is_low) begin
                        // join the surrogate pair
                        n_pend = 1'b0;
                        c0     = pair_cp;
                        cnt    = 2'd1;
                    end else begin
                        // flush an unpaired high surrogate first
                        if (r_pend) begin
                            c0     = CP_W'({HIGH_TAG, r_hs});
                            cnt    = 2'd1;
                            n_pend = 1'b0;
                        end
                        if (is_high) begin
                            n_pend = 1'b1;
                            n_hs   = unit[9:0];
                        end else if (r_pend) begin
                            c1  = CP_W'(unit);
                            cnt = 2'd2;
                        end else begin
                            c0  = CP_W'(unit);
                            cnt = 2'd1;
                        end
                    end
                end
            end
        endcase

        // End of string: flush a waiting high surrogate, return to start
        if (i_last_in) begin
            if (n_utf16 && n_pend) begin
                if (cnt == 2'd0) begin
                    c0  = CP_W'({HIGH_TAG, n_hs});
                    cnt = 2'd1;
                end else begin
                    c1  = CP_W'({HIGH_TAG, n_hs});
                    cnt = 2'd2;
                end
            end
            n_phase    = PH_START;
            n_utf16    = 1'b0;
            n_held_vld = 1'b0;
            n_pend     = 1'b0;
        end
    end

    // Issue an entry when there is a code point or the string ends
    assign o_push      = accept && ((cnt != 2'd0) || i_last_in);
    assign o_work.cp0  = c0;
    assign o_work.cp1  = c1;
    assign o_work.n_cp = cnt;
    assign o_work.last = i_last_in;

    // A waiting surrogate or half unit exists only inside a UTF-16 body
    a_pend_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_utf16 && r_phase == PH_BODY))
        else $error("surrogate pending outside UTF-16 body");

    a_held_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_vld |-> (r_utf16 && r_phase == PH_BODY))
        else $error("held byte outside UTF-16 body");

endmodule

/* hw/rtl/u16u8_queue.sv */
// ----------------------------------------------------------------------------
// u16u8_queue: work queue
// Small register FIFO of work entries between the front end and the
// byte encoder, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module u16u8_queue
    import u16u8_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_work o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_work            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    // Advance pointers with wrap
    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    // Write entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("pop from empty queue");

endmodule

/* hw/rtl/u16u8_back.sv */
// ----------------------------------------------------------------------------
// u16u8_back: UTF-8 byte encoder
// Takes the work entry at the queue head and emits its code points as UTF-8,
// one byte per cycle while the output is taken, into an output register.
// ----------------------------------------------------------------------------
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_work      i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_end_of_string,
    output logic       o_no_byte
);

    // Sequence length minus one
    function automatic logic [1:0] seq_len(input logic [CP_W-1:0] cp);
        logic [1:0] len;
        if (cp[20:16] != '0) begin
            len = 2'd3;
        end else if (cp[15:11] != '0) begin
            len = 2'd2;
        end else if (cp[10:7] != '0) begin
            len = 2'd1;
        end else begin
            len = 2'd0;
        end
        return len;
    endfunction

    // Byte idx of the UTF-8 sequence of cp
    function automatic logic [7:0] seq_byte(input logic [CP_W-1:0] cp,
                                            input logic [1:0] len,
                                            input logic [1:0] idx);
        logic [7:0] b;
        b = {2'b10, cp[5:0]};
        case (len)
            2'd0: b = cp[7:0];
            2'd1: begin
                if (idx == 2'd0) b = {3'b110, cp[10:6]};
            end
            2'd2: begin
                case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

    logic       r_slot;
    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_eos;
    logic       r_no_byte;

    logic [CP_W-1:0] cur_cp;
    logic [1:0]      cur_len;
    logic            marker;
    logic            last_of_cp;
    logic            last_of_entry;
    logic            emit;
    logic [7:0]      n_out_byte;

    // Select the current code point and byte
    assign cur_cp        = r_slot ? i_head.cp1 : i_head.cp0;
    assign cur_len       = seq_len(cur_cp);
    assign marker        = (i_head.n_cp == 2'd0);
    assign last_of_cp    = (r_idx == cur_len);
    assign last_of_entry = marker ||
                           (last_of_cp && ((i_head.n_cp != 2'd2) || r_slot));
    assign n_out_byte    = marker ? 8'h00 : seq_byte(cur_cp, cur_len, r_idx);

    assign emit  = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_pop = emit && last_of_entry;

    // Advance through the entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= 1'b0;
            r_idx  <= 2'd0;
        end else if (emit) begin
            if (last_of_entry) begin
                r_slot <= 1'b0;
                r_idx  <= 2'd0;
            end else if (last_of_cp) begin
                r_slot <= 1'b1;
                r_idx  <= 2'd0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Hold the output transfer until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= n_out_byte;
            r_eos      <= i_head.last && last_of_entry;
            r_no_byte  <= marker;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_end_of_string = r_eos;
    assign o_no_byte       = r_no_byte;

    // A marker transfer always closes the string and carries a zero byte
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_no_byte) |-> (r_eos && r_out_byte == 8'h00))
        else $error("malformed end marker");

endmodule

/* hw/rtl/utf16be_or_latin1_to_utf8.sv */
// ----------------------------------------------------------------------------
// utf16be_or_latin1_to_utf8: streaming text transcoder
// Reads a byte string as UTF-16BE when it opens with FE FF and as Latin-1
// otherwise, and emits UTF-8 bytes with an end-of-string flag.
// ----------------------------------------------------------------------------
// The front end takes one input byte per cycle whenever the work queue has
// room; the encoder behind the queue emits one UTF-8 byte per cycle while its
// output is taken. An input byte yields as many output bytes as its code
// points need: none for the first byte of a UTF-16 unit, for the byte order
// mark, for a high surrogate held for its partner or for a dropped odd
// trailing byte; one for ASCII; two for a Latin-1 byte from 80 up; one to
// three for other UTF-16 units and four for a joined surrogate pair; up to
// six for a high surrogate flushed together with another unit at the end of
// a string; and one transfer for an end marker. The front end takes input
// while the encoder works; the QUEUE_DEPTH-entry queue absorbs bursts.
// ----------------------------------------------------------------------------
module utf16be_or_latin1_to_utf8
    import u16u8_pkg::*;
#(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_last_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_end_of_string,
    output logic       o_no_byte
);

    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  q_valid;
    t_work q_in;
    t_work q_head;

    // Classify input bytes
    u16u8_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_last_in  (i_last_in),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_work     (q_in)
    );

    // Decouple front end and encoder
    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_work  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Encode code points into UTF-8 bytes
    u16u8_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_head          (q_head),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_end_of_string (o_end_of_string),
        .o_no_byte       (o_no_byte)
    );

endmodule
